@@ sv/pid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pid_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [14:0] MAX_OUTPUT_RESET = 15'h7FFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAX_OUTPUT          = 3'd0,
      REG_DEAD_BAND           = 3'd1,
      REG_INTEGRAL_LIMIT      = 3'd2,
      REG_INTEGRAL_SEPARATION = 3'd3,
      REG_DERIVATIVE_LIMIT    = 3'd4,
      REG_GAIN_P              = 3'd5,
      REG_GAIN_I              = 3'd6,
      REG_GAIN_D              = 3'd7
   } pid_reg_type;

   typedef struct packed {
      logic [14:0]        max_output;
      logic [15:0]        dead_band;
      logic [30:0]        integral_limit;
      logic [15:0]        integral_separation;
      logic [16:0]        derivative_limit;
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
   } pid_cfg_type;

   // sampled request word
   typedef struct packed {
      logic signed [15:0] measured;
      logic signed [15:0] setpoint;
      logic [14:0]        cap;
   } pid_sample_type;

   // error terms after the state update
   typedef struct packed {
      logic signed [16:0] err;
      logic signed [31:0] integral;
      logic signed [17:0] diff;
      logic               dead;
      logic [14:0]        cap;
   } pid_term_type;

   // weighted terms
   typedef struct packed {
      logic signed [32:0] prod_p;
      logic signed [47:0] prod_i;
      logic signed [33:0] prod_d;
      logic               dead;
      logic [14:0]        cap;
   } pid_prod_type;

endpackage

`default_nettype wire

@@ sv/pid_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pid_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] measured;
   logic signed [15:0] setpoint;
   logic [14:0]        cap;

   modport source (output valid, output measured, output setpoint, output cap, input ready);
   modport sink (input valid, input measured, input setpoint, input cap, output ready);
endinterface

`default_nettype wire

@@ sv/pid_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pid_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive;
   logic signed [15:0] capped_drive;
   logic               in_dead_band;

   modport source (output valid, output drive, output capped_drive, output in_dead_band,
                   input ready);
   modport sink (input valid, input drive, input capped_drive, input in_dead_band,
                 output ready);
endinterface

`default_nettype wire

@@ sv/pid_csr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pid_csr_if
   import pid_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/pid_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pid_update
   import pid_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pid_cfg_type    cfg,
   input  wire logic           in_valid,
   input  wire pid_sample_type in_word,
   input  wire logic           take,
   output logic                out_valid,
   output pid_term_type        out_word
);

   logic signed [16:0] prev_err_ff;
   logic signed [31:0] integral_ff;
   logic               valid_ff;
   pid_term_type       word_ff;

   logic signed [16:0] err;
   logic [16:0]        mag;
   logic               dead;
   logic               integrate;
   logic signed [32:0] acc;
   logic signed [31:0] acc_sat;
   logic signed [31:0] int_lim;
   logic signed [31:0] acc_clamp;
   logic signed [31:0] integral_in;
   logic signed [17:0] diff_raw;
   logic signed [17:0] diff_lim;
   logic signed [17:0] diff_in;
   pid_term_type       word_in;

   always_comb begin
      err       = 17'(in_word.setpoint) - 17'(in_word.measured);
      mag       = err[16] ? 17'(-err) : err;
      dead      = mag <= {1'b0, cfg.dead_band};
      integrate = (cfg.integral_separation == 16'd0) || (mag < {1'b0, cfg.integral_separation});

      acc = 33'(integral_ff) + 33'(err);
      // saturate to 32 bits when the top two bits disagree
      if (acc[32] != acc[31]) begin
         acc_sat = acc[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         acc_sat = acc[31:0];
      end

      int_lim = $signed({1'b0, cfg.integral_limit});
      acc_clamp = acc_sat;
      if (cfg.integral_limit != 31'd0) begin
         if (acc_sat > int_lim) begin
            acc_clamp = int_lim;
         end else if (acc_sat < -int_lim) begin
            acc_clamp = -int_lim;
         end
      end

      if (dead) begin
         integral_in = integral_ff;
      end else if (integrate) begin
         integral_in = acc_clamp;
      end else begin
         integral_in = 32'sd0;
      end

      diff_raw = 18'(err) - 18'(prev_err_ff);
      diff_lim = $signed({1'b0, cfg.derivative_limit});
      diff_in  = diff_raw;
      if (cfg.derivative_limit != 17'd0) begin
         if (diff_raw > diff_lim) begin
            diff_in = diff_lim;
         end else if (diff_raw < -diff_lim) begin
            diff_in = -diff_lim;
         end
      end

      word_in.err      = err;
      word_in.integral = integral_in;
      word_in.diff     = diff_in;
      word_in.dead     = dead;
      word_in.cap      = in_word.cap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         integral_ff <= '0;
         valid_ff    <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
         if (in_valid) begin
            prev_err_ff <= err;
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

@@ sv/pid_mult.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pid_mult
   import pid_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pid_cfg_type  cfg,
   input  wire logic         in_valid,
   input  wire pid_term_type in_word,
   input  wire logic         take,
   output logic              out_valid,
   output pid_prod_type      out_word
);

   logic         valid_ff;
   pid_prod_type word_ff;
   pid_prod_type word_in;

   // three independent signed products
   always_comb begin
      word_in.prod_p = 33'(cfg.gain_p) * 33'(in_word.err);
      word_in.prod_i = 48'(cfg.gain_i) * 48'(in_word.integral);
      word_in.prod_d = 34'(cfg.gain_d) * 34'(in_word.diff);
      word_in.dead   = in_word.dead;
      word_in.cap    = in_word.cap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

@@ sv/pid_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pid_scale
   import pid_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pid_cfg_type  cfg,
   input  wire logic         in_valid,
   input  wire pid_prod_type in_word,
   output logic              take,
   pid_rsp_if.source         rsp_chan
);

   logic               valid_ff;
   logic signed [15:0] drive_ff;
   logic signed [15:0] capped_ff;
   logic               dead_ff;

   logic signed [49:0] sum;
   logic signed [41:0] scaled;
   logic signed [41:0] max_lim;
   logic signed [15:0] drive_in;
   logic signed [15:0] cap_lim;
   logic signed [15:0] capped_in;

   always_comb begin
      sum    = 50'(in_word.prod_p) + 50'(in_word.prod_i) + 50'(in_word.prod_d) + 50'sd128;
      // arithmetic shift by 8 gives the floor
      scaled = sum[49:8];

      max_lim = $signed({27'd0, cfg.max_output});
      if (scaled > max_lim) begin
         drive_in = max_lim[15:0];
      end else if (scaled < -max_lim) begin
         drive_in = 16'(-max_lim);
      end else begin
         drive_in = scaled[15:0];
      end

      cap_lim = $signed({1'b0, in_word.cap});
      if (drive_in > cap_lim) begin
         capped_in = cap_lim;
      end else if (drive_in < -cap_lim) begin
         capped_in = -cap_lim;
      end else begin
         capped_in = drive_in;
      end

      if (in_word.dead) begin
         drive_in  = 16'sd0;
         capped_in = 16'sd0;
      end
   end

   assign take = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         drive_ff  <= drive_in;
         capped_ff <= capped_in;
         dead_ff   <= in_word.dead;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.drive        = drive_ff;
   assign rsp_chan.capped_drive = capped_ff;
   assign rsp_chan.in_dead_band = dead_ff;

endmodule

`default_nettype wire

@@ sv/pid_controller_step.sv @@
// positional pid controller step with dead band and anti-windup
//
// req_chan: one word per control sample (measured, setpoint, cap). rsp_chan: one
// word per request (drive, capped_drive, in_dead_band), in request order.
// csr_chan: register writes, always ready; write only while no request is in flight.
//
// four register stages: request capture, error/integral/derivative update, gain
// products, then scaling and clamps into the output register. one request per
// cycle is sustained while rsp_chan is ready; the stored error and integral are
// updated in a single stage, so back-to-back samples see each other's state.
//
// reset empties the pipeline, clears previous error and integral, sets max_output
// to full scale and all other registers to zero.
// when rsp_chan stalls the output word holds; earlier stages keep filling empty
// slots, and req_chan.ready drops only once every stage holds a word.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_step
   import pid_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pid_req_if.sink   req_chan,
   pid_rsp_if.source rsp_chan,
   pid_csr_if.sink   csr_chan
);

   pid_cfg_type    cfg_ff;
   logic           s1_valid_ff;
   pid_sample_type s1_word_ff;

   logic           s1_take;
   logic           s2_take;
   logic           s3_take;
   logic           out_take;
   logic           s2_valid;
   logic           s3_valid;
   pid_term_type   s2_word;
   pid_prod_type   s3_word;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_output          <= MAX_OUTPUT_RESET;
         cfg_ff.dead_band           <= '0;
         cfg_ff.integral_limit      <= '0;
         cfg_ff.integral_separation <= '0;
         cfg_ff.derivative_limit    <= '0;
         cfg_ff.gain_p              <= '0;
         cfg_ff.gain_i              <= '0;
         cfg_ff.gain_d              <= '0;
      end else if (csr_chan.valid) begin
         case (pid_reg_type'(csr_chan.index))
            REG_MAX_OUTPUT:          cfg_ff.max_output          <= csr_chan.data[14:0];
            REG_DEAD_BAND:           cfg_ff.dead_band           <= csr_chan.data[15:0];
            REG_INTEGRAL_LIMIT:      cfg_ff.integral_limit      <= csr_chan.data[30:0];
            REG_INTEGRAL_SEPARATION: cfg_ff.integral_separation <= csr_chan.data[15:0];
            REG_DERIVATIVE_LIMIT:    cfg_ff.derivative_limit    <= csr_chan.data[16:0];
            REG_GAIN_P:              cfg_ff.gain_p              <= $signed(csr_chan.data[15:0]);
            REG_GAIN_I:              cfg_ff.gain_i              <= $signed(csr_chan.data[15:0]);
            REG_GAIN_D:              cfg_ff.gain_d              <= $signed(csr_chan.data[15:0]);
            default: begin
            end
         endcase
      end
   end

   // each stage loads when it is empty or its word moves on
   assign s3_take = !s3_valid || out_take;
   assign s2_take = !s2_valid || s3_take;
   assign s1_take = !s1_valid_ff || s2_take;

   assign req_chan.ready = s1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_take) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && req_chan.valid) begin
         s1_word_ff.measured <= req_chan.measured;
         s1_word_ff.setpoint <= req_chan.setpoint;
         s1_word_ff.cap      <= req_chan.cap;
      end
   end

   pid_update u_update (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid_ff),
      .in_word   (s1_word_ff),
      .take      (s2_take),
      .out_valid (s2_valid),
      .out_word  (s2_word)
   );

   pid_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s2_valid),
      .in_word   (s2_word),
      .take      (s3_take),
      .out_valid (s3_valid),
      .out_word  (s3_word)
   );

   pid_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (s3_valid),
      .in_word  (s3_word),
      .take     (out_take),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ tb/pid_controller_step_test.sv @@
`timescale 1ns / 1ps

module pid_controller_step_test;
   import pid_pkg::*;

   localparam int     PIPE_DEPTH       = 4;
   localparam int     SETTLE_CYCLES    = PIPE_DEPTH + 6;
   localparam int     LONG_HOLD_CYCLES = 60;
   localparam int     CYCLE_LIMIT      = 600000;
   localparam int     RANDOM_PHASES    = 9;
   localparam int     PHASE_WORDS      = 44;
   localparam int     RISE_WORDS       = 20;
   localparam int     FALL_WORDS       = 20;
   localparam longint INT32_TOP        = 64'sd2147483647;
   localparam longint INT32_BOTTOM     = -64'sd2147483648;

   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [15:0] capped_drive;
      logic               in_dead_band;
   } drive_word_type;

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // shadow of the controller state plus the queue of drive words still owed
   class pid_mirror;
      pid_cfg_type        regs;
      logic signed [16:0] prev_err;
      logic signed [31:0] integral;
      drive_word_type     owed[$];
      int                 failures;

      function new();
         regs = '0;
         regs.max_output = MAX_OUTPUT_RESET;
         prev_err = '0;
         integral = '0;
         failures = 0;
      endfunction

      function void set_reg(pid_reg_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_MAX_OUTPUT:          regs.max_output = value[14:0];
            REG_DEAD_BAND:           regs.dead_band = value[15:0];
            REG_INTEGRAL_LIMIT:      regs.integral_limit = value[30:0];
            REG_INTEGRAL_SEPARATION: regs.integral_separation = value[15:0];
            REG_DERIVATIVE_LIMIT:    regs.derivative_limit = value[16:0];
            REG_GAIN_P:              regs.gain_p = value[15:0];
            REG_GAIN_I:              regs.gain_i = value[15:0];
            REG_GAIN_D:              regs.gain_d = value[15:0];
            default: ;
         endcase
      endfunction

      function void take_sample(pid_sample_type smp);
         longint         err;
         longint         mag;
         longint         acc;
         longint         diff;
         longint         sum;
         longint         drv;
         longint         cpd;
         drive_word_type w;
         err = longint'(smp.setpoint) - longint'(smp.measured);
         mag = (err < 0) ? -err : err;
         diff = err - longint'(prev_err);
         prev_err = err[16:0];
         if (mag <= longint'(regs.dead_band)) begin
            w = drive_word_type'{drive: '0, capped_drive: '0, in_dead_band: 1'b1};
            owed.push_back(w);
            return;
         end
         if (regs.integral_separation == '0 ||
             mag < longint'(regs.integral_separation)) begin
            acc = longint'(integral) + err;
            if (acc > INT32_TOP) acc = INT32_TOP;
            if (acc < INT32_BOTTOM) acc = INT32_BOTTOM;
            if (regs.integral_limit != '0)
               acc = clamp_sym(acc, longint'(regs.integral_limit));
            integral = acc[31:0];
         end else begin
            integral = '0;
         end
         if (regs.derivative_limit != '0)
            diff = clamp_sym(diff, longint'(regs.derivative_limit));
         sum = longint'(regs.gain_p) * err + longint'(regs.gain_i) * longint'(integral)
             + longint'(regs.gain_d) * diff;
         // q8.8 back to integer, ties go up
         drv = (sum + 128) >>> 8;
         drv = clamp_sym(drv, longint'(regs.max_output));
         cpd = clamp_sym(drv, longint'(smp.cap));
         w.drive = drv[15:0];
         w.capped_drive = cpd[15:0];
         w.in_dead_band = 1'b0;
         owed.push_back(w);
      endfunction

      function void flag(string msg);
         failures++;
         $error("%s", msg);
      endfunction

      function void check_drive(drive_word_type got);
         drive_word_type want;
         if (owed.size() == 0) begin
            flag($sformatf("response word with nothing owed: drive %0d", got.drive));
            return;
         end
         want = owed.pop_front();
         if (got.drive !== want.drive)
            flag($sformatf("drive: expected %0d, actual %0d", want.drive, got.drive));
         if (got.capped_drive !== want.capped_drive)
            flag($sformatf("capped_drive: expected %0d, actual %0d",
                           want.capped_drive, got.capped_drive));
         if (got.in_dead_band !== want.in_dead_band)
            flag($sformatf("in_dead_band: expected %0d, actual %0d",
                           want.in_dead_band, got.in_dead_band));
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idling_on;
   bit   long_hold;
   int   cycles = 0;

   pid_mirror mirror = new();

   pid_req_if req_chan ();
   pid_rsp_if rsp_chan ();
   pid_csr_if csr_chan ();

   pid_controller_step dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // check the response first so a word arriving with a new sample never matches it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            mirror.check_drive(drive_word_type'{rsp_chan.drive, rsp_chan.capped_drive,
                                                rsp_chan.in_dead_band});
         if (req_chan.valid && req_chan.ready)
            mirror.take_sample(pid_sample_type'{req_chan.measured, req_chan.setpoint,
                                                req_chan.cap});
      end
   end

   // response side: random stall bursts, plus one long hold on request
   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 9) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic offer_word(pid_sample_type smp);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.measured <= smp.measured;
      req_chan.setpoint <= smp.setpoint;
      req_chan.cap      <= smp.cap;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic offer(int meas, int sp, int cap);
      pid_sample_type smp;
      smp.measured = 16'(meas);
      smp.setpoint = 16'(sp);
      smp.cap      = 15'(cap);
      offer_word(smp);
   endtask

   task automatic write_reg(pid_reg_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      mirror.set_reg(idx, value);
   endtask

   task automatic load_config(pid_cfg_type c);
      write_reg(REG_MAX_OUTPUT, CSR_DATA_W'(c.max_output));
      write_reg(REG_DEAD_BAND, CSR_DATA_W'(c.dead_band));
      write_reg(REG_INTEGRAL_LIMIT, CSR_DATA_W'(c.integral_limit));
      write_reg(REG_INTEGRAL_SEPARATION, CSR_DATA_W'(c.integral_separation));
      write_reg(REG_DERIVATIVE_LIMIT, CSR_DATA_W'(c.derivative_limit));
      write_reg(REG_GAIN_P, CSR_DATA_W'(16'(c.gain_p)));
      write_reg(REG_GAIN_I, CSR_DATA_W'(16'(c.gain_i)));
      write_reg(REG_GAIN_D, CSR_DATA_W'(16'(c.gain_d)));
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // drop the request and let the pipeline run dry
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (mirror.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pid_cfg_type make_config(int max_out, int dband, int ilim, int sep,
                                                int dlim, int kp, int ki, int kd);
      pid_cfg_type c;
      c.max_output          = 15'(max_out);
      c.dead_band           = 16'(dband);
      c.integral_limit      = 31'(ilim);
      c.integral_separation = 16'(sep);
      c.derivative_limit    = 17'(dlim);
      c.gain_p              = 16'(kp);
      c.gain_i              = 16'(ki);
      c.gain_d              = 16'(kd);
      return c;
   endfunction

   function automatic logic signed [15:0] random_gain();
      case ($urandom_range(0, 4))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 2048)) - 16'sd1024;
      endcase
   endfunction

   function automatic pid_cfg_type random_config();
      pid_cfg_type c;
      case ($urandom_range(0, 4))
         0: c.max_output = '0;
         1: c.max_output = 15'h7FFF;
         2: c.max_output = 15'($urandom_range(0, 1000));
         default: c.max_output = 15'($urandom);
      endcase
      case ($urandom_range(0, 11))
         0: c.dead_band = 16'hFFFF;
         1: c.dead_band = 16'($urandom);
         2, 3, 4: c.dead_band = '0;
         default: c.dead_band = 16'($urandom_range(0, 100));
      endcase
      case ($urandom_range(0, 4))
         0: c.integral_limit = '0;
         1: c.integral_limit = 31'h7FFF_FFFF;
         2: c.integral_limit = 31'($urandom);
         default: c.integral_limit = 31'($urandom_range(1, 5000));
      endcase
      case ($urandom_range(0, 4))
         0, 1: c.integral_separation = '0;
         2: c.integral_separation = 16'hFFFF;
         default: c.integral_separation = 16'($urandom_range(10, 3000));
      endcase
      case ($urandom_range(0, 4))
         0, 1: c.derivative_limit = '0;
         2: c.derivative_limit = 17'h1FFFF;
         default: c.derivative_limit = 17'($urandom_range(1, 2000));
      endcase
      c.gain_p = random_gain();
      c.gain_i = random_gain();
      c.gain_d = random_gain();
      return c;
   endfunction

   function automatic int corner_value();
      case ($urandom_range(0, 4))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // errors near the thresholds of the current setting, random small errors, corner values and raw noise
   function automatic pid_sample_type random_sample(pid_cfg_type c);
      pid_sample_type smp;
      int             sp;
      int             meas;
      int             mag;
      int             err;
      int             kind;
      kind = $urandom_range(0, 9);
      sp   = $urandom_range(0, 40000) - 20000;
      case (kind)
         0, 1: mag = -1;
         2: mag = -2;
         3, 4: mag = int'(c.dead_band) + $urandom_range(0, 2) - 1;
         5: mag = int'(c.integral_separation) + $urandom_range(0, 2) - 1;
         default: mag = $urandom_range(0, 2500);
      endcase
      if (mag == -1) begin
         smp.measured = 16'($urandom);
         smp.setpoint = 16'($urandom);
      end else if (mag == -2) begin
         smp.measured = 16'(corner_value());
         smp.setpoint = 16'(corner_value());
      end else begin
         if (mag < 0) mag = 0;
         err  = $urandom_range(0, 1) ? -mag : mag;
         meas = sp - err;
         if (meas > 32767) meas = 32767;
         if (meas < -32768) meas = -32768;
         smp.measured = 16'(meas);
         smp.setpoint = 16'(sp);
      end
      case ($urandom_range(0, 7))
         0: smp.cap = '0;
         1: smp.cap = 15'h7FFF;
         2, 3: smp.cap = 15'($urandom_range(0, 500));
         default: smp.cap = 15'($urandom);
      endcase
      return smp;
   endfunction

   initial begin : stimulus
      pid_cfg_type c;
      reset             = 1'b1;
      idling_on         = 1'b1;
      long_hold         = 1'b0;
      req_chan.valid    = 1'b0;
      req_chan.measured = '0;
      req_chan.setpoint = '0;
      req_chan.cap      = '0;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = REG_MAX_OUTPUT;
      csr_chan.data     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // dead band, separation, integral and derivative clamps all active
      load_config(make_config(20000, 5, 1000, 3000, 500, 256, 64, -128));
      offer(-32768, 32767, 32767);
      offer(32767, -32768, 0);
      offer(0, 0, 100);
      offer(0, 5, 100);
      offer(0, -5, 100);
      offer(0, 6, 32767);
      offer(0, -6, 32767);
      offer(0, 2999, 32767);
      offer(0, 3000, 32767);
      repeat (3) offer(100, 1000, 32767);
      repeat (3) offer(1000, 100, 32767);
      offer(0, 2000, 50);
      settle();

      // half-lsb gain: rounding ties
      load_config(make_config(32767, 0, 0, 0, 0, 128, 0, 0));
      offer(0, 1, 32767);
      offer(0, -1, 32767);
      offer(0, 3, 32767);
      offer(0, -3, 32767);
      settle();

      // zero output bound with extreme gains
      load_config(make_config(0, 0, 0, 0, 0, 32767, -32768, 32767));
      offer(-32768, 32767, 32767);
      offer(32767, -32768, 32767);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            c = make_config(32767, 0, 32'h7FFF_FFFF, 16'hFFFF, 17'h1FFFF,
                            32767, -32768, 32767);
         else if (phase == 1)
            c = make_config(32767, 0, 0, 0, 1, -32768, 32767, -32768);
         else
            c = random_config();
         load_config(c);
         idling_on = ($urandom_range(0, 3) != 0);
         if (phase == 3) begin
            idling_on = 1'b0;
            long_hold = 1'b1;
         end
         repeat (PHASE_WORDS) offer_word(random_sample(c));
         settle();
      end

      // ramp the integral up and back down with full-range errors, no idling from here
      idling_on = 1'b0;
      load_config(make_config(32767, 0, 0, 0, 0, 0, 1, 0));
      repeat (RISE_WORDS) offer(-32768, 32767, $urandom_range(0, 32767));
      settle();
      write_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      repeat (FALL_WORDS) offer(32767, -32768, $urandom_range(0, 32767));
      settle();
      write_reg(REG_INTEGRAL_LIMIT, '0);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      repeat (8) offer(32767, -32768, $urandom_range(0, 32767));
      settle();

      if (mirror.owed.size() != 0)
         mirror.flag($sformatf("%0d response words never arrived", mirror.owed.size()));
      if (mirror.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ pid_controller_step.f @@
sv/pid_pkg.sv
sv/pid_req_if.sv
sv/pid_rsp_if.sv
sv/pid_csr_if.sv
sv/pid_update.sv
sv/pid_mult.sv
sv/pid_scale.sv
sv/pid_controller_step.sv
tb/pid_controller_step_test.sv
